[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk_i, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define RPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never seen out of reset
`define RPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/rps_pkg.sv]
// ---------------------------------------------------------------------------
// rps_pkg
// Shared widths, register indexes and pipeline types of the range stretch.
// ---------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  localparam int unsigned IN_W   = 16;  // raw pixel
  localparam int unsigned CFG_W  = 17;  // level registers
  localparam int unsigned PIX_W  = 17;  // pixel as signed value
  localparam int unsigned X_W    = 18;  // pixel minus low level
  localparam int unsigned D_W    = 18;  // high minus low
  localparam int unsigned MAG_W  = 17;  // |high - low|
  localparam int unsigned NUM_W  = 27;  // 510*x + d, signed
  localparam int unsigned QBITS  = 8;   // quotient bits
  localparam int unsigned OUT_W  = QBITS;
  localparam int unsigned REM_W  = MAG_W + 1 + QBITS;  // remainder < 256*|2d|
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned NSTAGE = 3 + QBITS;
  localparam int unsigned OCC_W  = $clog2(NSTAGE + 1);

  localparam logic signed [CFG_W-1:0] LOW_RST  = CFG_W'(0);
  localparam logic signed [CFG_W-1:0] HIGH_RST = CFG_W'(65535);

  typedef enum logic [IDX_W-1:0] {
    CFG_LOW_LEVEL    = 2'd0,
    CFG_HIGH_LEVEL   = 2'd1,
    CFG_SIGNED_INPUT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] lo;
    logic signed [D_W-1:0]   d;
    logic                    d_neg;
    logic                    d_zero;
    logic [MAG_W-1:0]        dmag;
    logic                    sign_in;
  } cfg_t;

  typedef struct packed {
    logic             force_q;  // quotient already fixed, skip division
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] q;
  } stg_t;

endpackage

`default_nettype wire

[rtl/pixel_range_stretch_16_to_8_core.sv]
// ---------------------------------------------------------------------------
// pixel_range_stretch_16_to_8_core
// Linear contrast stretch of 16-bit gray pixels to 8 bits, round half up.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while in_stall_o is low and returns one 8-bit
// pixel per transaction: offset, scale and range check stages come first,
// then a one-bit-per-stage divider resolves the quotient. Every stage
// holds its own valid bit, so bubbles close up under a stall and input
// keeps flowing while a result waits, until the pipe is full. Register
// writes reach later pixels once the span registers in rps_cfg follow.
`default_nettype none

module pixel_range_stretch_16_to_8_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rps_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rps_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [rps_pkg::IN_W-1:0]   sample_bits_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [rps_pkg::OUT_W-1:0]       out_pixel_o
);
  import rps_pkg::*;

  cfg_t              cfg;
  stg_t              stg [QBITS+1];
  logic [QBITS:0]    vld;
  logic [QBITS:0]    rdy;
  logic              front_rdy;
  logic [2:0]        front_vld;
  logic [OCC_W-1:0]  occ_q, occ_d;

  rps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (in_valid_i),
    .ready_o  (front_rdy),
    .sample_i (sample_bits_i),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .stg_o    (stg[0]),
    .vld_o    (front_vld)
  );

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    rps_div_stage #(
      .BIT_IDX (QBITS - 1 - k)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .dmag_i  (cfg.dmag),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .stg_i   (stg[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .stg_o   (stg[k+1])
    );
  end

  assign rdy[QBITS]  = !out_stall_i;
  assign in_stall_o  = !front_rdy;
  assign out_valid_o = vld[QBITS];
  assign out_pixel_o = stg[QBITS].q;

  // transactions in flight
  always_comb begin
    occ_d = occ_q;
    if (in_valid_i && front_rdy) occ_d = occ_d + OCC_W'(1);
    if (out_valid_o && !out_stall_i) occ_d = occ_d - OCC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `include "assert_macros.svh"

  `RPS_ASSERT(a_occ_match, occ_q == OCC_W'($countones({front_vld, vld[QBITS:1]})), "lost or duplicated transaction")
  `RPS_ASSERT(a_stall_full, in_stall_o |-> (occ_q == OCC_W'(NSTAGE)) && out_stall_i, "input stalled with room in pipe")
  `RPS_ASSERT(a_span_zero, cfg.d_zero == (cfg.dmag == '0), "span flags disagree")

endmodule

`default_nettype wire

[rtl/rps_cfg.sv]
// ---------------------------------------------------------------------------
// rps_cfg
// Configuration registers and the derived span terms used by the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module rps_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rps_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rps_pkg::CFG_W-1:0]  cfg_data_i,
  output rps_pkg::cfg_t                   cfg_o
);
  import rps_pkg::*;

  logic signed [CFG_W-1:0] low_q, high_q;
  logic                    sign_q;
  logic signed [D_W-1:0]   d_q, d_d;
  logic signed [D_W-1:0]   dd_q;
  logic [MAG_W-1:0]        dmag_q, dmag_d;
  logic                    dzero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RST;
      high_q <= HIGH_RST;
      sign_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_LEVEL:    low_q  <= cfg_data_i;
        CFG_HIGH_LEVEL:   high_q <= cfg_data_i;
        CFG_SIGNED_INPUT: sign_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign d_d    = D_W'(high_q) - D_W'(low_q);
  assign dmag_d = d_q[D_W-1] ? MAG_W'(-d_q) : MAG_W'(d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q     <= D_W'(HIGH_RST) - D_W'(LOW_RST);
      dd_q    <= D_W'(HIGH_RST) - D_W'(LOW_RST);
      dmag_q  <= MAG_W'(HIGH_RST - LOW_RST);
      dzero_q <= 1'b0;
    end else begin
      d_q     <= d_d;
      dd_q    <= d_q;
      dmag_q  <= dmag_d;
      dzero_q <= (d_q == '0);
    end
  end

  assign cfg_o.lo      = low_q;
  assign cfg_o.d       = dd_q;
  assign cfg_o.d_neg   = dd_q[D_W-1];
  assign cfg_o.d_zero  = dzero_q;
  assign cfg_o.dmag    = dmag_q;
  assign cfg_o.sign_in = sign_q;

endmodule

`default_nettype wire

[rtl/rps_front.sv]
// ---------------------------------------------------------------------------
// rps_front
// Offset, scale and range check: three stages feeding the quotient pipe.
// ---------------------------------------------------------------------------
`default_nettype none

module rps_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rps_pkg::cfg_t            cfg_i,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic [rps_pkg::IN_W-1:0] sample_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output rps_pkg::stg_t                 stg_o,
  output logic [2:0]                    vld_o
);
  import rps_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [PIX_W-1:0] pix;
  logic signed [X_W-1:0]   x_d, x_q;
  logic signed [NUM_W-1:0] sum, num_d, num_q;
  logic                    gt_q, gt2_q;
  stg_t                    stg_d, stg_q;
  logic [REM_W-1:0]        top_lim;

  assign rdy[2] = !vld_q[2] || ready_i;
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: pixel minus low level
  assign pix = cfg_i.sign_in ? PIX_W'($signed(sample_i)) : $signed({1'b0, sample_i});
  assign x_d = X_W'(pix) - X_W'(cfg_i.lo);

  // stage 2: 510*x + d, sign folded into numerator
  assign sum   = (NUM_W'(x_q) <<< 9) - (NUM_W'(x_q) <<< 1) + NUM_W'(cfg_i.d);
  assign num_d = cfg_i.d_neg ? -sum : sum;

  // stage 3: fixed results and saturation
  assign top_lim = {cfg_i.dmag, 1'b0, {QBITS{1'b0}}};

  always_comb begin
    stg_d.force_q = 1'b1;
    stg_d.rem     = REM_W'(num_q);
    stg_d.q       = '0;
    priority if (cfg_i.d_zero) begin
      stg_d.q = gt2_q ? '1 : '0;
    end else if (num_q[NUM_W-1]) begin
      stg_d.q = '0;
    end else if (REM_W'(num_q) >= top_lim) begin
      stg_d.q = '1;
    end else begin
      stg_d.force_q = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      x_q  <= x_d;
      gt_q <= !x_d[X_W-1] && (x_d != '0);
    end
    if (rdy[1] && vld_q[0]) begin
      num_q <= num_d;
      gt2_q <= gt_q;
    end
    if (rdy[2] && vld_q[1]) stg_q <= stg_d;
  end

  assign valid_o = vld_q[2];
  assign stg_o   = stg_q;
  assign vld_o   = vld_q;

endmodule

`default_nettype wire

[rtl/rps_div_stage.sv]
// ---------------------------------------------------------------------------
// rps_div_stage
// One restoring-division step: resolves one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rps_div_stage #(
  parameter int unsigned BIT_IDX = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [rps_pkg::MAG_W-1:0] dmag_i,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire rps_pkg::stg_t             stg_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output rps_pkg::stg_t                  stg_o
);
  import rps_pkg::*;

  logic             vld_q;
  stg_t             stg_d, stg_q;
  logic [REM_W-1:0] dsh;
  logic [REM_W:0]   diff;

  assign dsh  = REM_W'({dmag_i, 1'b0}) << BIT_IDX;
  assign diff = {1'b0, stg_i.rem} - {1'b0, dsh};

  always_comb begin
    stg_d = stg_i;
    if (!stg_i.force_q && !diff[REM_W]) begin
      stg_d.rem        = diff[REM_W-1:0];
      stg_d.q[BIT_IDX] = 1'b1;
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) stg_q <= stg_d;
  end

  assign valid_o = vld_q;
  assign stg_o   = stg_q;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Regression for the 16-to-8 bit linear contrast stretch core.
// ---------------------------------------------------------------------------
// Drives pixels through the valid/stall input channel and predicts each
// stretched pixel from a local copy of the level and sign registers. The
// predictor uses exact integer arithmetic with floor division and clamping.
// Results are checked in order against the queue of predicted pixels.
// Coverage comes from directed extremes, equal and inverted levels, and
// register masking. Random level phases follow, with idle bursts on both
// channels, a long output hold-off, a drain pause and a final stretch with no idling.
// ---------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rps_pkg::*;

  localparam int unsigned LAT_PAD     = 16;
  localparam int unsigned CFG_SETTLE  = 4;
  localparam int unsigned HOLD_CYC    = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORT  = 10;
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [IN_W-1:0]     sample_bits_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [OUT_W-1:0]    out_pixel_o;

  // local copy of the register file
  logic signed [CFG_W-1:0] lvl_low  = LOW_RST;
  logic signed [CFG_W-1:0] lvl_high = HIGH_RST;
  logic                    sign_mode = 1'b0;

  logic [OUT_W-1:0] pix_exp_q[$];
  logic [OUT_W-1:0] pix_want;
  int unsigned      err_cnt = 0;
  bit               tx_gaps = 1'b0;
  bit               rx_gaps = 1'b0;
  bit               rx_hold_req = 1'b0;

  pixel_range_stretch_16_to_8_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_bits_i (sample_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_pixel_o   (out_pixel_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [OUT_W-1:0] stretch_pixel(input logic [IN_W-1:0] raw);
    longint lo, hi, d, p, num, den, q, r;
    lo = longint'(lvl_low);
    hi = longint'(lvl_high);
    d  = hi - lo;
    if (sign_mode) begin
      p = longint'($signed(raw));
    end else begin
      p = longint'(raw);
    end
    if (d == 0) begin
      q = (p > lo) ? 255 : 0;
    end else begin
      num = 510 * (p - lo) + d;
      den = 2 * d;
      q   = num / den;
      r   = num % den;
      if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
      if (q > 255) q = 255;
      else if (q < 0) q = 0;
    end
    return q[OUT_W-1:0];
  endfunction

  task automatic send_pixel(input logic [IN_W-1:0] raw);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_bits_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    pix_exp_q.push_back(stretch_pixel(raw));
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pix_exp_q.size() != 0) @(posedge clk_i);
    repeat (LAT_PAD) @(posedge clk_i);
  endtask

  // caller lowers cfg_we_i after the last write of a series
  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LOW_LEVEL:    lvl_low   = data;
      CFG_HIGH_LEVEL:   lvl_high  = data;
      CFG_SIGNED_INPUT: sign_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic load_levels(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic sgn);
    stop_sending();
    wait_idle();
    set_reg(CFG_LOW_LEVEL, lo);
    set_reg(CFG_HIGH_LEVEL, hi);
    set_reg(CFG_SIGNED_INPUT, {{(CFG_W-1){1'b0}}, sgn});
    cfg_we_i <= 1'b0;
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic test_default_map();
    send_pixel(16'h0000);
    send_pixel(16'h0001);
    send_pixel(16'h0080);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'hFFFE);
    send_pixel(16'hFFFF);
  endtask

  task automatic test_signed_extremes();
    load_levels(-17'sd32768, 17'sd32767, 1'b1);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    load_levels(17'h10000, 17'h0FFFF, 1'b0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
  endtask

  task automatic test_equal_levels();
    load_levels(17'd100, 17'd100, 1'b0);
    send_pixel(16'd99);
    send_pixel(16'd100);
    send_pixel(16'd101);
    load_levels(-17'sd1, -17'sd1, 1'b1);
    send_pixel(16'hFFFE);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
  endtask

  task automatic test_inverted_levels();
    load_levels(17'h0FFFF, -17'sd32768, 1'b0);
    send_pixel(16'h0000);
    send_pixel(16'h8000);
    send_pixel(16'hFFFF);
  endtask

  task automatic test_reg_masking();
    stop_sending();
    wait_idle();
    set_reg(CFG_SIGNED_INPUT, 17'h1FFFE);
    set_reg(CFG_IDX_SPARE, 17'h1FFFF);
    cfg_we_i <= 1'b0;
    repeat (CFG_SETTLE) @(posedge clk_i);
    send_pixel(16'hFFFF);
    send_pixel(16'h4000);
  endtask

  task automatic test_random_stretch();
    int base, span, lo_v, hi_v, m, p;
    logic sgn;
    int unsigned kind;
    for (int ph = 0; ph < 16; ph++) begin
      sgn  = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 3);
      base = sgn ? int'($urandom_range(0, 65535)) - 32768 : int'($urandom_range(0, 65535));
      span = $urandom_range(1, 1 << $urandom_range(0, 16));
      if ($urandom_range(0, 3) == 0) span = -span;
      case (kind)
        0: begin
          base = $urandom_range(0, 17'h1FFFF);
          span = int'($urandom_range(0, 17'h1FFFF)) - base;
        end
        3: span = 0;
        default: ;
      endcase
      load_levels(CFG_W'(base), CFG_W'(base + span), sgn);
      lo_v = (span < 0) ? base + span : base;
      hi_v = (span < 0) ? base : base + span;
      m    = (hi_v - lo_v) / 8 + 2;
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        if (kind != 0 && $urandom_range(0, 3) != 0) begin
          p = int'($urandom_range(0, hi_v - lo_v + 2 * m)) + lo_v - m;
          send_pixel(p[IN_W-1:0]);
        end else begin
          send_pixel(IN_W'($urandom_range(0, 16'hFFFF)));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    load_levels(17'd1000, 17'd3000, 1'b0);
    tx_gaps     = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_pixel(IN_W'($urandom_range(0, 4095)));
  endtask

  task automatic test_drain_pause();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (int i = 0; i < 20; i++) send_pixel(IN_W'($urandom_range(0, 16'hFFFF)));
    stop_sending();
    while (pix_exp_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 20; i++) send_pixel(IN_W'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic test_streaming_no_idle();
    load_levels(-17'sd2000, 17'sd2000, 1'b1);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (int i = 0; i < 250; i++) begin
      if (i[0]) send_pixel(IN_W'($urandom_range(0, 16'hFFFF)));
      else send_pixel(16'(int'($urandom_range(0, 4800)) - 2400));
    end
    stop_sending();
  endtask

  initial begin : rx_stall_proc
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pix_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORT)
          $display("unexpected transaction: out_pixel=%0d", out_pixel_o);
      end else begin
        pix_want = pix_exp_q.pop_front();
        if (out_pixel_o !== pix_want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORT)
            $display("out_pixel mismatch: expected %0d actual %0d", pix_want, out_pixel_o);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("pixel_range_stretch_16_to_8_core regression: fail");
    $finish;
  end

  initial begin : main_seq
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_LOW_LEVEL;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    sample_bits_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_default_map();
    test_signed_extremes();
    test_equal_levels();
    test_inverted_levels();
    test_reg_masking();
    test_random_stretch();
    test_backpressure();
    test_drain_pause();
    test_streaming_no_idle();

    while (pix_exp_q.size() != 0) @(posedge clk_i);
    repeat (LAT_PAD) @(posedge clk_i);
    if (pix_exp_q.size() != 0) err_cnt++;

    if (err_cnt == 0) begin
      $display("pixel_range_stretch_16_to_8_core regression: pass");
    end else begin
      $display("pixel_range_stretch_16_to_8_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rps_pkg.sv
rtl/rps_cfg.sv
rtl/rps_front.sv
rtl/rps_div_stage.sv
rtl/pixel_range_stretch_16_to_8_core.sv
dv/tb_top.sv
